// ----- rtl/cpr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants for the controller poll responder
// Command codes, poll packings, the reply descriptor that passes from the
// classifier through the queue to the serialiser, and small helpers.
// ----------------------------------------------------------------------------
package cpr_pkg;

  // queue depth between classifier and serialiser
  localparam int QUEUE_DEPTH_DEF = 2;

  // flash size less one sector
  localparam logic [31:0] FW_LIMIT_RESET = 32'd2093056;

  // longest reply run in bytes
  localparam int REPLY_MAX = 10;
  localparam int IDX_W     = $clog2(REPLY_MAX);

  // console command codes
  localparam logic [7:0] CMD_ID        = 8'h00;
  localparam logic [7:0] CMD_RESET     = 8'hFF;
  localparam logic [7:0] CMD_POLL      = 8'h40;
  localparam logic [7:0] CMD_ORIGIN    = 8'h41;
  localparam logic [7:0] CMD_CALIBRATE = 8'h42;
  localparam logic [7:0] CMD_LONG_POLL = 8'h43;
  localparam logic [7:0] CMD_VERSION   = 8'h44;
  localparam logic [7:0] CMD_FW_SIZE   = 8'h45;

  // fixed reply bytes
  localparam logic [7:0] ID_BYTE0   = 8'h09;
  localparam logic [7:0] ID_BYTE1   = 8'h00;
  localparam logic [7:0] ID_BYTE2   = 8'h03;
  localparam logic [7:0] FW_ACCEPT  = 8'h00;
  localparam logic [7:0] FW_REFUSE  = 8'h01;
  localparam logic [7:0] PAD_BYTE   = 8'h00;

  // highest poll mode taken from the argument
  localparam logic [7:0] POLL_MODE_MAX = 8'h04;

  // reply lengths, as index of the final byte
  localparam logic [IDX_W-1:0] LAST_SHORT = IDX_W'(2);
  localparam logic [IDX_W-1:0] LAST_ONE   = IDX_W'(0);
  localparam logic [IDX_W-1:0] LAST_POLL  = IDX_W'(7);
  localparam logic [IDX_W-1:0] LAST_LONG  = IDX_W'(9);

  typedef enum logic [2:0] {
    MODE_0,
    MODE_1,
    MODE_2,
    MODE_3,
    MODE_4,
    MODE_5
  } poll_mode_t;

  // one complete reply run
  typedef struct packed {
    logic [REPLY_MAX-1:0][7:0] bytes;
    logic [IDX_W-1:0]          last_idx;
    logic                      boot;
    logic                      origin;
  } reply_desc_t;

  // queue occupancy seen by the classifier and serialiser
  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  // high nibbles of two values packed into one byte
  function automatic logic [7:0] nibbles(input logic [7:0] hi, input logic [7:0] lo);
    return {hi[7:4], lo[7:4]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cpr_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_front: command classifier
// Accepts a command beat, decodes it and builds the full reply run with its
// length and flags, then pushes it into the reply queue. Unknown commands
// are taken and dropped.
// ----------------------------------------------------------------------------
module cpr_front (
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [7:0]           in_command,
  input  wire logic [31:0]          in_argument,
  input  wire logic [15:0]          in_buttons,
  input  wire logic [7:0]           in_main_stick_x,
  input  wire logic [7:0]           in_main_stick_y,
  input  wire logic [7:0]           in_second_stick_x,
  input  wire logic [7:0]           in_second_stick_y,
  input  wire logic [7:0]           in_trigger_left,
  input  wire logic [7:0]           in_trigger_right,
  input  wire logic [31:0]          fw_limit,
  input  wire cpr_pkg::queue_stat_t q_stat,
  output logic                      push,
  output cpr_pkg::reply_desc_t      push_desc
);
  import cpr_pkg::*;

  logic        accept;
  logic        known;
  poll_mode_t  mode;
  logic [7:0]  cnib;
  logic [7:0]  tnib;

  // beat taken whenever the queue has room
  assign busy   = q_stat.full;
  assign accept = start & ~busy;
  assign push   = accept & known;

  assign cnib = nibbles(in_second_stick_x, in_second_stick_y);
  assign tnib = nibbles(in_trigger_left, in_trigger_right);

  // poll mode select, out of range falls back to mode 0
  always_comb begin
    mode = MODE_0;
    unique case (in_command)
      CMD_POLL: begin
        if (in_argument[7:0] > POLL_MODE_MAX) begin
          mode = MODE_0;
        end else begin
          mode = poll_mode_t'(in_argument[2:0]);
        end
      end
      CMD_ORIGIN, CMD_CALIBRATE, CMD_LONG_POLL: begin
        mode = MODE_5;
      end
      default: begin
        mode = MODE_0;
      end
    endcase
  end

  // build the reply run
  always_comb begin
    push_desc          = '0;
    known              = 1'b1;
    push_desc.bytes[0] = in_buttons[15:8];
    push_desc.bytes[1] = in_buttons[7:0];
    push_desc.bytes[2] = in_main_stick_x;
    push_desc.bytes[3] = in_main_stick_y;
    push_desc.bytes[4] = in_second_stick_x;
    push_desc.bytes[5] = in_second_stick_y;
    push_desc.bytes[6] = in_trigger_left;
    push_desc.bytes[7] = in_trigger_right;
    push_desc.last_idx = LAST_POLL;

    // packing of the sample
    unique case (mode)
      MODE_0: begin
        push_desc.bytes[6] = tnib;
        push_desc.bytes[7] = PAD_BYTE;
      end
      MODE_1: begin
        push_desc.bytes[4] = cnib;
        push_desc.bytes[5] = in_trigger_left;
        push_desc.bytes[6] = in_trigger_right;
        push_desc.bytes[7] = PAD_BYTE;
      end
      MODE_2: begin
        push_desc.bytes[4] = cnib;
        push_desc.bytes[5] = tnib;
        push_desc.bytes[6] = PAD_BYTE;
        push_desc.bytes[7] = PAD_BYTE;
      end
      MODE_3: begin
        push_desc.last_idx = LAST_POLL;
      end
      MODE_4: begin
        push_desc.bytes[6] = PAD_BYTE;
        push_desc.bytes[7] = PAD_BYTE;
      end
      default: begin
        push_desc.bytes[8] = PAD_BYTE;
        push_desc.bytes[9] = PAD_BYTE;
        push_desc.last_idx = LAST_LONG;
      end
    endcase

    // fixed replies and flags
    unique case (in_command)
      CMD_ID, CMD_RESET: begin
        push_desc.bytes[0] = ID_BYTE0;
        push_desc.bytes[1] = ID_BYTE1;
        push_desc.bytes[2] = ID_BYTE2;
        push_desc.last_idx = LAST_SHORT;
      end
      CMD_VERSION: begin
        push_desc.bytes[0] = PAD_BYTE;
        push_desc.bytes[1] = PAD_BYTE;
        push_desc.bytes[2] = PAD_BYTE;
        push_desc.last_idx = LAST_SHORT;
      end
      CMD_FW_SIZE: begin
        push_desc.last_idx = LAST_ONE;
        if (in_argument <= fw_limit) begin
          push_desc.bytes[0] = FW_ACCEPT;
          push_desc.boot     = 1'b1;
        end else begin
          push_desc.bytes[0] = FW_REFUSE;
        end
      end
      CMD_ORIGIN: begin
        push_desc.origin = 1'b1;
      end
      CMD_POLL, CMD_CALIBRATE, CMD_LONG_POLL: begin
        known = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/cpr_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_queue: reply queue
// Short register FIFO of complete reply runs between the classifier and the
// serialiser, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module cpr_queue #(
  parameter int DEPTH = cpr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire cpr_pkg::reply_desc_t push_desc,
  input  wire logic                 pop,
  output cpr_pkg::reply_desc_t      head,
  output cpr_pkg::queue_stat_t      q_stat
);
  import cpr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  reply_desc_t      store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r,  count_nxt;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign head         = store_r[rd_ptr_r];

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_desc;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("reply queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("reply queue popped while empty");

  a_fill_rises: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("reply queue fill count lost a push");
`endif

endmodule
`default_nettype wire

// ----- rtl/cpr_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_back: reply serialiser
// Walks the run at the head of the queue one byte per cycle into the output
// registers, flags the final byte and pops the run after it.
// ----------------------------------------------------------------------------
module cpr_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cpr_pkg::reply_desc_t head,
  input  wire cpr_pkg::queue_stat_t q_stat,
  output logic                      pop,
  output logic                      out_valid,
  output logic [7:0]                out_reply_byte,
  output logic                      out_last_byte,
  output logic                      out_enter_bootloader,
  output logic                      out_origin_clear
);
  import cpr_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic             boot_r, boot_nxt;
  logic             origin_r, origin_nxt;
  logic             at_last;

  assign at_last = (idx_r == head.last_idx);
  assign pop     = ~q_stat.empty & at_last;

  // next beat from the head run
  always_comb begin
    valid_nxt  = ~q_stat.empty;
    byte_nxt   = head.bytes[idx_r];
    last_nxt   = at_last;
    boot_nxt   = at_last & head.boot;
    origin_nxt = head.origin;
    idx_nxt    = idx_r;
    if (!q_stat.empty) begin
      idx_nxt = at_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // beat payload, no reset
  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    last_r   <= last_nxt;
    boot_r   <= boot_nxt;
    origin_r <= origin_nxt;
  end

  assign out_valid            = valid_r;
  assign out_reply_byte       = byte_r;
  assign out_last_byte        = last_r;
  assign out_enter_bootloader = boot_r;
  assign out_origin_clear     = origin_r;

`ifndef SYNTHESIS
  a_boot_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && boot_r) |-> last_r) else $error("bootloader flag off the final byte");

  a_run_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !last_r) |=> valid_r) else $error("reply run broken mid-way");
`endif

endmodule
`default_nettype wire

// ----- rtl/controller_poll_responder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// controller_poll_responder: console command responder
// Decodes one console command with the current controller sample and sends
// the reply run one byte per beat.
//
//   channel  ports                          handshake
//   in       start/busy, in_*               taken when start & !busy
//   out      out_valid, out_*               one cycle per beat, no stall
//   cfg      cfg_wr_en, cfg_wr_data         written when cfg_wr_en
//
// A reply runs one to ten beats, one beat per cycle, set by the serialiser.
// A taken run is written into the queue; its first beat is then registered by the serialiser.
// The queue holds QUEUE_DEPTH runs; busy rises only while it is full.
// Unknown commands are taken and give no beats.
// Reset clears the queue and serialiser and reloads the size limit.
// ----------------------------------------------------------------------------
module controller_poll_responder #(
  parameter int QUEUE_DEPTH = cpr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_command,
  input  wire logic [31:0] in_argument,
  input  wire logic [15:0] in_buttons,
  input  wire logic [7:0]  in_main_stick_x,
  input  wire logic [7:0]  in_main_stick_y,
  input  wire logic [7:0]  in_second_stick_x,
  input  wire logic [7:0]  in_second_stick_y,
  input  wire logic [7:0]  in_trigger_left,
  input  wire logic [7:0]  in_trigger_right,
  output logic             out_valid,
  output logic [7:0]       out_reply_byte,
  output logic             out_last_byte,
  output logic             out_enter_bootloader,
  output logic             out_origin_clear,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data
);
  import cpr_pkg::*;

  logic [31:0] fw_limit_r;
  logic [31:0] fw_limit_nxt;
  logic        push;
  logic        pop;
  reply_desc_t push_desc;
  reply_desc_t head;
  queue_stat_t q_stat;

  // firmware size limit register
  assign fw_limit_nxt = cfg_wr_en ? cfg_wr_data : fw_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_limit_r <= FW_LIMIT_RESET;
    end else begin
      fw_limit_r <= fw_limit_nxt;
    end
  end

  cpr_front u_front (
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_argument       (in_argument),
    .in_buttons        (in_buttons),
    .in_main_stick_x   (in_main_stick_x),
    .in_main_stick_y   (in_main_stick_y),
    .in_second_stick_x (in_second_stick_x),
    .in_second_stick_y (in_second_stick_y),
    .in_trigger_left   (in_trigger_left),
    .in_trigger_right  (in_trigger_right),
    .fw_limit          (fw_limit_r),
    .q_stat            (q_stat),
    .push              (push),
    .push_desc         (push_desc)
  );

  cpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  cpr_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .head                 (head),
    .q_stat               (q_stat),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_reply_byte       (out_reply_byte),
    .out_last_byte        (out_last_byte),
    .out_enter_bootloader (out_enter_bootloader),
    .out_origin_clear     (out_origin_clear)
  );

endmodule
`default_nettype wire

// ----- sim/controller_poll_responder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// controller_poll_responder_tb: self-checking bench for the poll responder
// Sends console commands with random controller samples in bursts, predicts
// every reply beat from the command, the sample and the size limit, and
// checks each beat on the result ports against the oldest beat due. The
// size limit is rewritten between phases once all replies have drained.
// ----------------------------------------------------------------------------
module controller_poll_responder_tb;
  import cpr_pkg::*;

  // controller sample as sent in a poll reply
  typedef struct packed {
    logic [15:0] buttons;
    logic [7:0]  main_x;
    logic [7:0]  main_y;
    logic [7:0]  c_x;
    logic [7:0]  c_y;
    logic [7:0]  trig_l;
    logic [7:0]  trig_r;
  } pad_sample_t;

  typedef struct packed {
    logic [7:0]  command;
    logic [31:0] argument;
    pad_sample_t pad;
  } joy_request_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       boot;
    logic       origin;
  } reply_beat_t;

  // reply predictor and the beats it still waits for
  class reply_tracker;
    reply_beat_t reply_beats_due[$];
    logic [31:0] size_limit = FW_LIMIT_RESET;
    int          errors     = 0;
    int          n_requests = 0;
    int          n_replies  = 0;
    int          n_ignored  = 0;
    int          n_beats    = 0;
    int          n_boot     = 0;
    int          n_refused  = 0;
    logic [5:0]  modes_seen = '0;

    function logic [7:0] high_halves(logic [7:0] hi, logic [7:0] lo);
      return (hi & 8'hF0) | (lo >> 4);
    endfunction

    // work out the reply run of one taken command
    function void note_request(joy_request_t r);
      logic [7:0]  b [10];
      int          len;
      logic        boot;
      logic        origin;
      logic        from_sample;
      poll_mode_t  mode;
      reply_beat_t beat;
      len         = 0;
      boot        = 1'b0;
      origin      = 1'b0;
      from_sample = 1'b0;
      mode        = MODE_0;
      n_requests++;
      case (r.command)
        CMD_ID, CMD_RESET: begin
          b[0] = ID_BYTE0; b[1] = ID_BYTE1; b[2] = ID_BYTE2;
          len = 3;
        end
        CMD_VERSION: begin
          b[0] = PAD_BYTE; b[1] = PAD_BYTE; b[2] = PAD_BYTE;
          len = 3;
        end
        CMD_FW_SIZE: begin
          len = 1;
          if (r.argument <= size_limit) begin
            b[0] = FW_ACCEPT;
            boot = 1'b1;
            n_boot++;
          end else begin
            b[0] = FW_REFUSE;
            n_refused++;
          end
        end
        CMD_POLL: begin
          from_sample = 1'b1;
          mode = (r.argument[7:0] > POLL_MODE_MAX) ? MODE_0 : poll_mode_t'(r.argument[2:0]);
        end
        CMD_ORIGIN: begin
          from_sample = 1'b1;
          origin = 1'b1;
          mode = MODE_5;
        end
        CMD_CALIBRATE, CMD_LONG_POLL: begin
          from_sample = 1'b1;
          mode = MODE_5;
        end
        default: begin
          n_ignored++;
        end
      endcase

      // sample packings: first four bytes are common, the rest per mode
      if (from_sample) begin
        modes_seen[mode] = 1'b1;
        b[0] = r.pad.buttons[15:8];
        b[1] = r.pad.buttons[7:0];
        b[2] = r.pad.main_x;
        b[3] = r.pad.main_y;
        b[4] = r.pad.c_x;
        b[5] = r.pad.c_y;
        b[6] = r.pad.trig_l;
        b[7] = r.pad.trig_r;
        b[8] = PAD_BYTE;
        b[9] = PAD_BYTE;
        len  = 8;
        case (mode)
          MODE_0: begin
            b[6] = high_halves(r.pad.trig_l, r.pad.trig_r);
            b[7] = PAD_BYTE;
          end
          MODE_1: begin
            b[4] = high_halves(r.pad.c_x, r.pad.c_y);
            b[5] = r.pad.trig_l;
            b[6] = r.pad.trig_r;
            b[7] = PAD_BYTE;
          end
          MODE_2: begin
            b[4] = high_halves(r.pad.c_x, r.pad.c_y);
            b[5] = high_halves(r.pad.trig_l, r.pad.trig_r);
            b[6] = PAD_BYTE;
            b[7] = PAD_BYTE;
          end
          MODE_3: begin
          end
          MODE_4: begin
            b[6] = PAD_BYTE;
            b[7] = PAD_BYTE;
          end
          default: begin
            len = 10;
          end
        endcase
      end

      if (len > 0) n_replies++;
      for (int k = 0; k < len; k++) begin
        beat.data   = b[k];
        beat.last   = (k == len - 1);
        beat.boot   = (k == len - 1) && boot;
        beat.origin = origin;
        reply_beats_due.push_back(beat);
      end
    endfunction

    // compare one beat seen on the result ports with the oldest one due
    function void check_beat(reply_beat_t got);
      reply_beat_t want;
      if (reply_beats_due.size() == 0) begin
        $error("unexpected beat: reply_byte=%h last=%b boot=%b origin=%b",
               got.data, got.last, got.boot, got.origin);
        errors++;
        return;
      end
      want = reply_beats_due.pop_front();
      n_beats++;
      if (got.data !== want.data) begin
        $error("reply_byte: expected %h, got %h", want.data, got.data);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_byte: expected %b, got %b", want.last, got.last);
        errors++;
      end
      if (got.boot !== want.boot) begin
        $error("enter_bootloader: expected %b, got %b", want.boot, got.boot);
        errors++;
      end
      if (got.origin !== want.origin) begin
        $error("origin_clear: expected %b, got %b", want.origin, got.origin);
        errors++;
      end
    endfunction
  endclass

  logic        clk                  = 1'b0;
  logic        rst_n                = 1'b0;
  logic        start                = 1'b0;
  logic        busy;
  logic [7:0]  in_command           = '0;
  logic [31:0] in_argument          = '0;
  logic [15:0] in_buttons           = '0;
  logic [7:0]  in_main_stick_x      = '0;
  logic [7:0]  in_main_stick_y      = '0;
  logic [7:0]  in_second_stick_x    = '0;
  logic [7:0]  in_second_stick_y    = '0;
  logic [7:0]  in_trigger_left      = '0;
  logic [7:0]  in_trigger_right     = '0;
  logic        out_valid;
  logic [7:0]  out_reply_byte;
  logic        out_last_byte;
  logic        out_enter_bootloader;
  logic        out_origin_clear;
  logic        cfg_wr_en            = 1'b0;
  logic [31:0] cfg_wr_data          = '0;

  reply_tracker replies = new();
  logic [31:0]  limit_plan [5];

  controller_poll_responder dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_command           (in_command),
    .in_argument          (in_argument),
    .in_buttons           (in_buttons),
    .in_main_stick_x      (in_main_stick_x),
    .in_main_stick_y      (in_main_stick_y),
    .in_second_stick_x    (in_second_stick_x),
    .in_second_stick_y    (in_second_stick_y),
    .in_trigger_left      (in_trigger_left),
    .in_trigger_right     (in_trigger_right),
    .out_valid            (out_valid),
    .out_reply_byte       (out_reply_byte),
    .out_last_byte        (out_last_byte),
    .out_enter_bootloader (out_enter_bootloader),
    .out_origin_clear     (out_origin_clear),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reply monitor: every valid beat is checked at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      replies.check_beat(reply_beat_t'{out_reply_byte, out_last_byte,
                                       out_enter_bootloader, out_origin_clear});
    end
  end

  function automatic joy_request_t make_request(logic [7:0] cmd, logic [31:0] arg,
                                                pad_sample_t pad);
    joy_request_t r;
    r.command  = cmd;
    r.argument = arg;
    r.pad      = pad;
    return r;
  endfunction

  function automatic pad_sample_t random_pad();
    return pad_sample_t'({$urandom, $urandom});
  endfunction

  // mostly well-formed commands, some noise
  function automatic joy_request_t random_request(logic [31:0] limit);
    int          sel;
    logic [7:0]  cmd;
    logic [31:0] arg;
    sel = $urandom_range(0, 99);
    arg = $urandom;
    if (sel < 40) begin
      cmd = CMD_POLL;
      if ($urandom_range(0, 4) != 0) arg[7:0] = 8'($urandom_range(0, 4));
    end else if (sel < 55) begin
      cmd = CMD_ORIGIN + 8'($urandom_range(0, 2));
    end else if (sel < 63) begin
      cmd = $urandom_range(0, 1) ? CMD_ID : CMD_RESET;
    end else if (sel < 70) begin
      cmd = CMD_VERSION;
    end else if (sel < 85) begin
      cmd = CMD_FW_SIZE;
      case ($urandom_range(0, 3))
        0: arg = limit - 32'd1;
        1: arg = limit;
        2: arg = limit + 32'd1;
        default: arg = $urandom;
      endcase
    end else begin
      cmd = 8'($urandom_range(0, 255));
    end
    return make_request(cmd, arg, random_pad());
  endfunction

  // hold one command on the ports until it is taken
  task automatic send_request(input joy_request_t r);
    start             <= 1'b1;
    in_command        <= r.command;
    in_argument       <= r.argument;
    in_buttons        <= r.pad.buttons;
    in_main_stick_x   <= r.pad.main_x;
    in_main_stick_y   <= r.pad.main_y;
    in_second_stick_x <= r.pad.c_x;
    in_second_stick_y <= r.pad.c_y;
    in_trigger_left   <= r.pad.trig_l;
    in_trigger_right  <= r.pad.trig_r;
    do @(posedge clk); while (busy);
    replies.note_request(r);
  endtask

  task automatic idle(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // wait for every due beat with start held low, then idle before returning
  task automatic pause_until_drained();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (replies.reply_beats_due.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    pause_until_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    replies.size_limit = value;
  endtask

  // bursts of random length with random gaps, some back to back
  task automatic run_random(input int target);
    int done_at;
    int burst;
    done_at = replies.n_requests + target;
    while (replies.n_requests < done_at) begin
      burst = $urandom_range(1, 12);
      repeat (burst) send_request(random_request(replies.size_limit));
      case ($urandom_range(0, 9))
        0: pause_until_drained();
        1, 2, 3: begin
        end
        default: idle($urandom_range(1, 11));
      endcase
    end
  endtask

  initial begin
    limit_plan[0] = '0;
    limit_plan[1] = '1;
    limit_plan[2] = $urandom;
    limit_plan[3] = 32'd1;
    limit_plan[4] = FW_LIMIT_RESET;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: fixed replies, size check edges, every packing, noise codes
    send_request(make_request(CMD_ID, '0, '0));
    send_request(make_request(CMD_RESET, '1, '1));
    send_request(make_request(CMD_VERSION, '1, random_pad()));
    send_request(make_request(CMD_FW_SIZE, '0, random_pad()));
    send_request(make_request(CMD_FW_SIZE, FW_LIMIT_RESET, random_pad()));
    send_request(make_request(CMD_FW_SIZE, FW_LIMIT_RESET + 32'd1, random_pad()));
    send_request(make_request(CMD_FW_SIZE, '1, random_pad()));
    for (int m = 0; m <= 5; m++) begin
      send_request(make_request(CMD_POLL, 32'(m), (m % 2) ? random_pad() : '1));
    end
    send_request(make_request(CMD_POLL, '1, '1));
    send_request(make_request(CMD_POLL, 32'hFFFF_FF03, '0));
    send_request(make_request(CMD_ORIGIN, '1, '1));
    send_request(make_request(CMD_CALIBRATE, '0, '0));
    send_request(make_request(CMD_LONG_POLL, $urandom, random_pad()));
    // codes next to real ones are ignored
    send_request(make_request(CMD_ID + 8'd1, '1, random_pad()));
    send_request(make_request(CMD_FW_SIZE + 8'd1, '0, random_pad()));
    send_request(make_request(CMD_POLL - 8'd1, $urandom, random_pad()));
    send_request(make_request(CMD_RESET - 8'd1, $urandom, random_pad()));

    // random phases: one at the reset limit, then one after each limit write
    run_random(62);
    foreach (limit_plan[i]) begin
      write_limit(limit_plan[i]);
      run_random(62);
    end

    pause_until_drained();
    if (replies.reply_beats_due.size() != 0) begin
      $error("%0d reply beats never arrived", replies.reply_beats_due.size());
      replies.errors++;
    end

    $display("Run: %0d commands (%0d replied, %0d ignored), %0d beats checked, packings seen %b",
             replies.n_requests, replies.n_replies, replies.n_ignored, replies.n_beats,
             replies.modes_seen);
    $display("Size checks: %0d accepted, %0d refused over six limits incl. 0 and max",
             replies.n_boot, replies.n_refused);
    if (replies.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cpr_pkg.sv
rtl/cpr_front.sv
rtl/cpr_queue.sv
rtl/cpr_back.sv
rtl/controller_poll_responder.sv
sim/controller_poll_responder_tb.sv
